/* hw/rtl/page_frame_replacer_fifo_lru_top_macros.svh */
// Assertion macros for the page frame replacer.
// Included by every RTL file that carries concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef PAGE_FRAME_REPLACER_FIFO_LRU_TOP_MACROS_SVH
`define PAGE_FRAME_REPLACER_FIFO_LRU_TOP_MACROS_SVH

`ifndef SYNTH
`define PFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("page frame replacer assertion failed");
`define PFR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("page frame replacer assertion failed");
`else
`define PFR_ASSERT_IMP(lbl, ante, cons)
`define PFR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/pfr_pkg.sv */
// Shared types and constants of the page frame replacer.
// No dependencies; imported by the engine and the top level.
package pfr_pkg;

  localparam int FRAMES_DFLT     = 8;
  localparam int SWAP_SLOTS_DFLT = 16;
  localparam int STAMP_BITS_DFLT = 32;

  localparam int PAGES_PER_PROC = 16;
  localparam int PROC_IDS       = 256;
  localparam int PROC_W         = $clog2(PROC_IDS);
  localparam int PAGE_W         = $clog2(PAGES_PER_PROC);

  localparam int FRAME_OUT_W = 3;
  localparam int SLOT_OUT_W  = 4;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  typedef struct packed {
    logic [PAGE_W-1:0] virt_page;
    logic [PROC_W-1:0] proc_id;
  } pfr_req_t;

  typedef struct packed {
    logic                   status;
    logic [SLOT_OUT_W-1:0]  restored_slot;
    logic                   restored;
    logic [SLOT_OUT_W-1:0]  victim_slot;
    logic [PAGE_W-1:0]      victim_page;
    logic [PROC_W-1:0]      victim_proc;
    logic                   evicted;
    logic [FRAME_OUT_W-1:0] frame_used;
    logic                   hit;
  } pfr_result_t;

endpackage

/* hw/rtl/page_frame_replacer_fifo_lru_top.sv */
// One request is worked on at a time; the frame table scan and, on a miss, the swap table scan,
// one RAM entry per cycle, set how long each request takes, and no new request is taken until
// the engine has handed on its result. The result register lets the next request enter while a result waits.
// Reset clears all valid bits, the FIFO pointer, the access clock and the mode; no clearing pass.
module page_frame_replacer_fifo_lru_top
  import pfr_pkg::*;
#(
  parameter int FRAMES     = FRAMES_DFLT,
  parameter int SWAP_SLOTS = SWAP_SLOTS_DFLT,
  parameter int STAMP_BITS = STAMP_BITS_DFLT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // proc_id [7:0], virt_page [11:8], zero [15:12]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // hit [0], frame_used [3:1], evicted [4], victim_proc [12:5], victim_page [16:13],
  // victim_slot [20:17], restored [21], restored_slot [25:22], status [26], zero [31:27]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int RES_W = $bits(pfr_result_t);

  logic                  mode_q;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  pfr_req_t              req;
  pfr_result_t           res;
  logic                  res_valid;
  logic                  res_ready;

  assign req.proc_id   = s_axis_tdata[PROC_W-1:0];
  assign req.virt_page = s_axis_tdata[PROC_W +: PAGE_W];
  assign res_ready     = !out_valid_q || m_axis_tready;

  pfr_engine #(
    .FRAMES     (FRAMES),
    .SWAP_SLOTS (SWAP_SLOTS),
    .STAMP_BITS (STAMP_BITS)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .replace_mode_i (mode_q),
    .req_valid_i    (s_axis_tvalid),
    .req_ready_o    (s_axis_tready),
    .req_i          (req),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {{(OUT_DATA_W-RES_W){1'b0}}, res};
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* hw/rtl/pfr_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module pfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/pfr_engine.sv */
// Request sequencer of the page frame replacer: scans the frame and swap tables held in RAMs,
// chooses the frame and victim, and writes the tables back. Depends on pfr_pkg, pfr_ram and the macros header.
`include "page_frame_replacer_fifo_lru_top_macros.svh"

module pfr_engine
  import pfr_pkg::*;
#(
  parameter int FRAMES     = FRAMES_DFLT,
  parameter int SWAP_SLOTS = SWAP_SLOTS_DFLT,
  parameter int STAMP_BITS = STAMP_BITS_DFLT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        replace_mode_i,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  pfr_req_t    req_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output pfr_result_t res_o
);

  localparam int FW  = $clog2(FRAMES);
  localparam int SW  = $clog2(SWAP_SLOTS);
  localparam int FDW = PROC_W + PAGE_W + STAMP_BITS;
  localparam int SDW = PROC_W + PAGE_W;
  localparam logic [FW:0]   FRAMES_C = (FW+1)'(FRAMES);
  localparam logic [SW:0]   SLOTS_C  = (SW+1)'(SWAP_SLOTS);
  localparam logic [FW-1:0] FLAST    = FW'(FRAMES - 1);

  typedef enum logic [1:0] {S_IDLE, S_FSCAN, S_SSCAN, S_COMMIT} state_e;

  state_e                state_q;
  pfr_req_t              req_q;
  logic [FRAMES-1:0]     fvalid_q;
  logic [SWAP_SLOTS-1:0] svalid_q;
  logic [FW-1:0]         fifo_ptr_q;
  logic [STAMP_BITS-1:0] clock_q;

  logic [FW:0]           fa_q;
  logic                  frd_q;
  logic [FW-1:0]         fidx_q;
  logic [SW:0]           sa_q;
  logic                  srd_q;
  logic [SW-1:0]         sidx_q;

  logic                  hit_q;
  logic [FW-1:0]         hidx_q;
  logic                  ffree_q;
  logic [FW-1:0]         free_idx_q;
  logic [STAMP_BITS-1:0] min_stamp_q;
  logic [FW-1:0]         min_idx_q;
  logic [PROC_W-1:0]     min_proc_q;
  logic [PAGE_W-1:0]     min_page_q;
  logic [PROC_W-1:0]     fifo_proc_q;
  logic [PAGE_W-1:0]     fifo_page_q;

  logic [FW-1:0]         f_q;
  logic                  evict_q;
  logic [PROC_W-1:0]     vproc_q;
  logic [PAGE_W-1:0]     vpage_q;
  logic                  sfree_q;
  logic [SW-1:0]         sslot_q;
  logic                  rfound_q;
  logic [SW-1:0]         rslot_q;

  logic [FDW-1:0]        frdata;
  logic [SDW-1:0]        srdata;
  logic [PROC_W-1:0]     fr_proc;
  logic [PAGE_W-1:0]     fr_page;
  logic [STAMP_BITS-1:0] fr_stamp;
  logic [PROC_W-1:0]     sr_proc;
  logic [PAGE_W-1:0]     sr_page;
  logic                  full;
  logic                  commit;
  logic [FW-1:0]         fifo_next;
  logic [SWAP_SLOTS-1:0] svalid_d;

  assign fr_proc   = frdata[FDW-1 -: PROC_W];
  assign fr_page   = frdata[STAMP_BITS +: PAGE_W];
  assign fr_stamp  = frdata[STAMP_BITS-1:0];
  assign sr_proc   = srdata[SDW-1 -: PROC_W];
  assign sr_page   = srdata[PAGE_W-1:0];
  assign full      = evict_q && !sfree_q;
  assign commit    = (state_q == S_COMMIT) && res_ready_i && !full;
  assign fifo_next = (f_q == FLAST) ? '0 : f_q + FW'(1);

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_COMMIT);

  pfr_ram #(
    .WIDTH (FDW),
    .DEPTH (FRAMES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (f_q),
    .wdata_i ({req_q.proc_id, req_q.virt_page, clock_q}),
    .raddr_i (fa_q[FW-1:0]),
    .rdata_o (frdata)
  );

  pfr_ram #(
    .WIDTH (SDW),
    .DEPTH (SWAP_SLOTS)
  ) u_swap_ram (
    .clk_i   (clk_i),
    .we_i    (commit && evict_q),
    .waddr_i (sslot_q),
    .wdata_i ({vproc_q, vpage_q}),
    .raddr_i (sa_q[SW-1:0]),
    .rdata_o (srdata)
  );

  always_comb begin
    res_o = '0;
    if (full) begin
      res_o.status = 1'b1;
    end else begin
      res_o.hit        = hit_q;
      res_o.frame_used = FRAME_OUT_W'(f_q);
      res_o.evicted    = evict_q;
      if (evict_q) begin
        res_o.victim_proc = vproc_q;
        res_o.victim_page = vpage_q;
        res_o.victim_slot = SLOT_OUT_W'(sslot_q);
      end
      res_o.restored = rfound_q;
      if (rfound_q) begin
        res_o.restored_slot = SLOT_OUT_W'(rslot_q);
      end
    end
  end

  always_comb begin
    svalid_d = svalid_q;
    if (evict_q) begin
      svalid_d[sslot_q] = 1'b1;
    end
    if (rfound_q) begin
      svalid_d[rslot_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      fvalid_q    <= '0;
      svalid_q    <= '0;
      fifo_ptr_q  <= '0;
      clock_q     <= '0;
      fa_q        <= '0;
      frd_q       <= 1'b0;
      fidx_q      <= '0;
      sa_q        <= '0;
      srd_q       <= 1'b0;
      sidx_q      <= '0;
      hit_q       <= 1'b0;
      hidx_q      <= '0;
      ffree_q     <= 1'b0;
      free_idx_q  <= '0;
      min_stamp_q <= '0;
      min_idx_q   <= '0;
      min_proc_q  <= '0;
      min_page_q  <= '0;
      fifo_proc_q <= '0;
      fifo_page_q <= '0;
      f_q         <= '0;
      evict_q     <= 1'b0;
      vproc_q     <= '0;
      vpage_q     <= '0;
      sfree_q     <= 1'b0;
      sslot_q     <= '0;
      rfound_q    <= 1'b0;
      rslot_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            req_q    <= req_i;
            fa_q     <= '0;
            frd_q    <= 1'b0;
            sa_q     <= '0;
            srd_q    <= 1'b0;
            hit_q    <= 1'b0;
            ffree_q  <= 1'b0;
            evict_q  <= 1'b0;
            sfree_q  <= 1'b0;
            rfound_q <= 1'b0;
            state_q  <= S_FSCAN;
          end
        end
        S_FSCAN: begin
          if (fa_q < FRAMES_C) begin
            fa_q   <= fa_q + (FW+1)'(1);
            frd_q  <= 1'b1;
            fidx_q <= fa_q[FW-1:0];
          end else begin
            frd_q <= 1'b0;
          end
          if (frd_q) begin
            if (fvalid_q[fidx_q] && fr_proc == req_q.proc_id && fr_page == req_q.virt_page
                && !hit_q) begin
              hit_q  <= 1'b1;
              hidx_q <= fidx_q;
            end
            if (!fvalid_q[fidx_q] && !ffree_q) begin
              ffree_q    <= 1'b1;
              free_idx_q <= fidx_q;
            end
            if (fidx_q == '0 || fr_stamp < min_stamp_q) begin
              min_stamp_q <= fr_stamp;
              min_idx_q   <= fidx_q;
              min_proc_q  <= fr_proc;
              min_page_q  <= fr_page;
            end
            if (fidx_q == fifo_ptr_q) begin
              fifo_proc_q <= fr_proc;
              fifo_page_q <= fr_page;
            end
          end
          if (fa_q == FRAMES_C && !frd_q) begin
            if (hit_q) begin
              f_q     <= hidx_q;
              state_q <= S_COMMIT;
            end else if (ffree_q) begin
              f_q     <= free_idx_q;
              state_q <= S_SSCAN;
            end else begin
              evict_q <= 1'b1;
              if (replace_mode_i) begin
                f_q     <= min_idx_q;
                vproc_q <= min_proc_q;
                vpage_q <= min_page_q;
              end else begin
                f_q     <= fifo_ptr_q;
                vproc_q <= fifo_proc_q;
                vpage_q <= fifo_page_q;
              end
              state_q <= S_SSCAN;
            end
          end
        end
        S_SSCAN: begin
          if (sa_q < SLOTS_C) begin
            sa_q   <= sa_q + (SW+1)'(1);
            srd_q  <= 1'b1;
            sidx_q <= sa_q[SW-1:0];
          end else begin
            srd_q <= 1'b0;
          end
          if (srd_q) begin
            if (!svalid_q[sidx_q] && !sfree_q) begin
              sfree_q <= 1'b1;
              sslot_q <= sidx_q;
            end
            if (svalid_q[sidx_q] && sr_proc == req_q.proc_id && sr_page == req_q.virt_page
                && !rfound_q) begin
              rfound_q <= 1'b1;
              rslot_q  <= sidx_q;
            end
          end
          if (sa_q == SLOTS_C && !srd_q) begin
            state_q <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (res_ready_i) begin
            if (!full) begin
              fvalid_q[f_q] <= 1'b1;
              svalid_q      <= svalid_d;
              clock_q       <= clock_q + STAMP_BITS'(1);
              if (evict_q && !replace_mode_i) begin
                fifo_ptr_q <= fifo_next;
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `PFR_ASSERT_IMP(a_victim_slot_free, state_q == S_COMMIT && evict_q && sfree_q, !svalid_q[sslot_q])
  `PFR_ASSERT_IMP(a_restore_slot_held, state_q == S_COMMIT && rfound_q, svalid_q[rslot_q])
  `PFR_ASSERT_IMP(a_hit_frame_valid, state_q == S_COMMIT && hit_q, fvalid_q[f_q] && !evict_q)
  `PFR_ASSERT_NXT(a_clock_advance, commit, clock_q == $past(clock_q) + STAMP_BITS'(1))

endmodule
